// ===== rtl/core/simon128_pkg.sv =====
// ----------------------------------------------------------------------------
// simon128_pkg
// Shared widths, constants, codes, types and mode decode functions for the
// digit-serial SIMON 128-bit block encryption engine.
// ----------------------------------------------------------------------------
package simon128_pkg;

  // Word and digit geometry
  localparam int unsigned WORD_W        = 64;
  localparam int unsigned DIGIT_W       = 16;
  localparam int unsigned NUM_DIG       = WORD_W / DIGIT_W;
  localparam int unsigned DIG_W         = $clog2(NUM_DIG);
  localparam logic [DIG_W-1:0] DIG_LAST = DIG_W'(NUM_DIG - 1);

  // Round key store geometry: one entry per digit of each round key
  localparam int unsigned ROUND_KEY_DEPTH = 72;
  localparam int unsigned RND_W           = $clog2(ROUND_KEY_DEPTH);
  localparam int unsigned RK_ADDR_W       = RND_W + DIG_W;
  localparam int unsigned RK_ENTRIES      = ROUND_KEY_DEPTH * NUM_DIG;

  // Key words and configuration
  localparam int unsigned NUM_KEY_WORDS = 4;
  localparam int unsigned KW_CNT_W      = 3;
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned CFG_IDX_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE   = 3'd4;

  localparam logic [MODE_W-1:0] MODE_128 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_192 = 2'd1;

  // Key schedule constant c and the round constant sequences. Bits above
  // 63 carry the sequence bits for derived keys past the 64th.
  localparam logic [WORD_W-1:0] ROUND_C = 64'hffff_ffff_ffff_fffc;
  localparam int unsigned SEQ_W = ROUND_KEY_DEPTH;
  localparam logic [SEQ_W-1:0] SEQ_Z2 = {8'h01, 64'h7369_f885_192c_0ef5};
  localparam logic [SEQ_W-1:0] SEQ_Z3 = {8'h02, 64'hfc2c_e512_07a6_35db};
  localparam logic [SEQ_W-1:0] SEQ_Z4 = {8'h02, 64'hfdc9_4c3a_046d_678b};

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [NUM_KEY_WORDS-1:0][WORD_W-1:0] key_words_t;

  // Control from the sequencer to the round key unit
  typedef struct packed {
    logic                 expand;
    logic [RND_W-1:0]     rnd;
    logic [DIG_W-1:0]     dig;
    logic [RK_ADDR_W-1:0] rd_addr;
  } ks_ctrl_t;

  // Number of key words for a key size code; unused codes act as 256-bit
  function automatic logic [KW_CNT_W-1:0] key_word_count(input logic [MODE_W-1:0] mode);
    logic [KW_CNT_W-1:0] cnt;
    case (mode)
      MODE_128: cnt = 3'd2;
      MODE_192: cnt = 3'd3;
      default:  cnt = 3'd4;
    endcase
    return cnt;
  endfunction

  function automatic logic [RND_W-1:0] round_count(input logic [MODE_W-1:0] mode);
    logic [RND_W-1:0] cnt;
    case (mode)
      MODE_128: cnt = 7'd68;
      MODE_192: cnt = 7'd69;
      default:  cnt = 7'd72;
    endcase
    return cnt;
  endfunction

  function automatic logic [SEQ_W-1:0] seq_init(input logic [MODE_W-1:0] mode);
    logic [SEQ_W-1:0] seq;
    case (mode)
      MODE_128: seq = SEQ_Z2;
      MODE_192: seq = SEQ_Z3;
      default:  seq = SEQ_Z4;
    endcase
    return seq;
  endfunction

endpackage

// ===== rtl/core/simon128_if.sv =====
// ----------------------------------------------------------------------------
// simon128_if
// Valid/ready channels of the SIMON engine: plaintext blocks, ciphertext
// blocks and configuration register writes.
// ----------------------------------------------------------------------------
interface simon128_in_if;
  logic                        valid;
  logic                        ready;
  logic [simon128_pkg::WORD_W-1:0] plain_left;
  logic [simon128_pkg::WORD_W-1:0] plain_right;

  modport source (output valid, output plain_left, output plain_right, input ready);
  modport sink   (input valid, input plain_left, input plain_right, output ready);
endinterface

interface simon128_out_if;
  logic                        valid;
  logic                        ready;
  logic [simon128_pkg::WORD_W-1:0] cipher_left;
  logic [simon128_pkg::WORD_W-1:0] cipher_right;

  modport source (output valid, output cipher_left, output cipher_right, input ready);
  modport sink   (input valid, input cipher_left, input cipher_right, output ready);
endinterface

interface simon128_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [simon128_pkg::CFG_IDX_W-1:0] index;
  logic [simon128_pkg::WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/simon_128_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// simon_128_block_encrypt
// SIMON encryption, 128-bit block with 128, 192 or 256-bit key, computed
// one 16-bit digit per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   cfg    : register writes (index 0..3 key words, most significant first,
//            index 4 key size code). Taken only while the engine is idle.
//            Any write to a listed register schedules a new key expansion.
//   plain  : one plaintext block (x word, y word) per transfer.
//   cipher : one ciphertext block per plaintext block, in order.
// Operation, with 68, 69 or 72 rounds for the 128, 192 or 256-bit key:
//   - The round unit handles one 16-bit digit of the x/y words per cycle,
//     reading one round key digit from the store.
//   - The first block after a key write first expands the round keys into
//     the store, one key digit per cycle.
//   - A new block is taken only once the previous result has entered the
//     output register.
// Reset clears the key registers and marks the round keys as pending.
// A stalled result stays in the output register while the next block is
// taken and encrypted; that block then waits until the register frees up.
// ----------------------------------------------------------------------------
module simon_128_block_encrypt (
  input  logic             clk,
  input  logic             rst,
  simon128_cfg_if.sink     cfg,
  simon128_in_if.sink      plain,
  simon128_out_if.source   cipher
);

  localparam int unsigned W = simon128_pkg::WORD_W;
  localparam int unsigned D = simon128_pkg::DIGIT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXP  = 2'd1;
  localparam logic [1:0] ST_ENC  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                          state;
  logic [1:0]                          state_next;
  logic                                expanded;
  simon128_pkg::key_words_t            key_word;
  logic [simon128_pkg::MODE_W-1:0]     mode;
  logic [simon128_pkg::RND_W-1:0]      rnd;
  logic [simon128_pkg::DIG_W-1:0]      dig;
  simon128_pkg::word_t                 x;
  simon128_pkg::word_t                 y;
  simon128_pkg::word_t                 out_left;
  simon128_pkg::word_t                 out_right;
  logic                                out_valid;

  logic                                cfg_xfer;
  logic                                cfg_hit;
  logic                                in_xfer;
  logic                                out_free;
  logic                                need_exp;
  logic                                last_dig;
  logic                                last_step;
  logic [simon128_pkg::RND_W-1:0]      total;
  logic [simon128_pkg::RND_W-1:0]      rnd_inc;
  logic [simon128_pkg::DIG_W-1:0]      dig_inc;
  logic [simon128_pkg::RK_ADDR_W-1:0]  next_addr;
  simon128_pkg::ks_ctrl_t              ks_ctrl;
  simon128_pkg::digit_t                rk_digit;
  logic [D+7:0]                        win;
  simon128_pkg::digit_t                f_dig;
  simon128_pkg::digit_t                new_dig;

  // Handshakes; hold both inputs off during reset
  assign cfg.ready    = (state == ST_IDLE) && !rst;
  assign plain.ready  = (state == ST_IDLE) && !rst;
  assign cfg_xfer     = cfg.valid & cfg.ready;
  assign in_xfer      = plain.valid & plain.ready;
  assign cfg_hit      = cfg_xfer && (cfg.index == simon128_pkg::REG_KEY_WORD_0 ||
                                     cfg.index == simon128_pkg::REG_KEY_WORD_1 ||
                                     cfg.index == simon128_pkg::REG_KEY_WORD_2 ||
                                     cfg.index == simon128_pkg::REG_KEY_WORD_3 ||
                                     cfg.index == simon128_pkg::REG_KEY_SIZE);
  assign need_exp     = !expanded || cfg_hit;
  assign out_free     = !out_valid || cipher.ready;

  assign cipher.valid        = out_valid;
  assign cipher.cipher_left  = out_left;
  assign cipher.cipher_right = out_right;

  // Round and digit position
  always_comb begin
    total     = simon128_pkg::round_count(mode);
    last_dig  = (dig == simon128_pkg::DIG_LAST);
    last_step = last_dig && (rnd == total - 7'd1);
    rnd_inc   = rnd + 7'd1;
    dig_inc   = dig + 2'd1;
    next_addr = last_dig ? {rnd_inc, {simon128_pkg::DIG_W{1'b0}}} : {rnd, dig_inc};
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_xfer) state_next = need_exp ? ST_EXP : ST_ENC;
      ST_EXP:  if (last_step) state_next = ST_ENC;
      ST_ENC:  if (last_step) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      expanded <= 1'b0;
      rnd      <= '0;
      dig      <= '0;
    end else begin
      state <= state_next;
      if (cfg_hit) begin
        expanded <= 1'b0;
      end else if (state == ST_EXP && last_step) begin
        expanded <= 1'b1;
      end
      if (in_xfer || ((state == ST_EXP || state == ST_ENC) && last_step)) begin
        rnd <= '0;
        dig <= '0;
      end else if (state == ST_EXP || state == ST_ENC) begin
        dig <= dig_inc;
        if (last_dig) begin
          rnd <= rnd_inc;
        end
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_word <= '0;
      mode     <= simon128_pkg::MODE_128;
    end else if (cfg_xfer) begin
      case (cfg.index)
        simon128_pkg::REG_KEY_WORD_0: key_word[0] <= cfg.data;
        simon128_pkg::REG_KEY_WORD_1: key_word[1] <= cfg.data;
        simon128_pkg::REG_KEY_WORD_2: key_word[2] <= cfg.data;
        simon128_pkg::REG_KEY_WORD_3: key_word[3] <= cfg.data;
        simon128_pkg::REG_KEY_SIZE:   mode        <= cfg.data[simon128_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Round key unit; prefetch the next key digit into the registered read data
  always_comb begin
    ks_ctrl.expand  = (state == ST_EXP);
    ks_ctrl.rnd     = rnd;
    ks_ctrl.dig     = dig;
    ks_ctrl.rd_addr = (state == ST_ENC && !last_step) ? next_addr : '0;
  end

  simon128_key_sched u_key_sched (
    .clk      (clk),
    .key_word (key_word),
    .mode     (mode),
    .ctrl     (ks_ctrl),
    .rk_digit (rk_digit)
  );

  // Round digit: x rotates right by a digit each cycle, so x rol 1, 8 and 2
  // come from the low digit plus the top byte
  always_comb begin
    win     = {x[D-1:0], x[W-1:W-8]};
    f_dig   = (win[D+6:7] & win[D-1:0]) ^ win[D+5:6];
    new_dig = y[D-1:0] ^ f_dig ^ rk_digit;
  end

  // Shift new x digits into y; swap roles at the end of each round
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x <= plain.plain_left;
      y <= plain.plain_right;
    end else if (state == ST_ENC) begin
      if (last_dig) begin
        x <= {new_dig, y[W-1:D]};
        y <= {x[D-1:0], x[W-1:D]};
      end else begin
        x <= {x[D-1:0], x[W-1:D]};
        y <= {new_dig, y[W-1:D]};
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (cipher.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_left  <= x;
      out_right <= y;
    end
  end

  // Checks
  a_enc_needs_keys: assert property (@(posedge clk) disable iff (rst)
    state == ST_ENC |-> expanded)
    else $error("encryption running without expanded round keys");

  a_exp_only_pending: assert property (@(posedge clk) disable iff (rst)
    state == ST_EXP |-> !expanded)
    else $error("expansion running while keys already expanded");

  a_rnd_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXP || state == ST_ENC) |-> rnd < total)
    else $error("round counter past the round count");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == ST_EXP || state == ST_ENC))
    else $error("accepted block did not start work");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result presented without finishing a block");

endmodule

// ===== rtl/core/simon128_key_sched.sv =====
// ----------------------------------------------------------------------------
// simon128_key_sched
// Digit-serial round key expansion and the round key store. One key digit
// is produced and written per expansion cycle; the store is read one digit
// per cycle with registered read data.
// ----------------------------------------------------------------------------
module simon128_key_sched (
  input  logic                                clk,
  input  simon128_pkg::key_words_t            key_word,
  input  logic [simon128_pkg::MODE_W-1:0]     mode,
  input  simon128_pkg::ks_ctrl_t              ctrl,
  output simon128_pkg::digit_t                rk_digit
);

  localparam int unsigned W = simon128_pkg::WORD_W;
  localparam int unsigned D = simon128_pkg::DIGIT_W;

  // Last four round keys, newest in entry 0, rotating one digit per cycle
  simon128_pkg::word_t   kq [simon128_pkg::NUM_KEY_WORDS];
  simon128_pkg::word_t   nk;
  logic [simon128_pkg::SEQ_W-1:0] seq;
  simon128_pkg::digit_t  rk_mem [simon128_pkg::RK_ENTRIES];

  logic [simon128_pkg::KW_CNT_W-1:0] num_w;
  logic [simon128_pkg::KW_CNT_W-1:0] src_calc;
  logic [1:0]            src_idx;
  logic [1:0]            old_idx;
  logic                  loading;
  logic                  wide_key;
  logic                  last_dig;
  logic                  first_step;
  simon128_pkg::word_t   src_word;
  simon128_pkg::word_t   old_word;
  simon128_pkg::digit_t  load_dig;
  simon128_pkg::digit_t  c_dig;
  simon128_pkg::digit_t  seq_mask;
  simon128_pkg::digit_t  t_lo;
  simon128_pkg::digit_t  t_hi;
  simon128_pkg::digit_t  calc_dig;
  simon128_pkg::digit_t  key_dig;

  // Decode key size and the phase of the current key
  always_comb begin
    num_w      = simon128_pkg::key_word_count(mode);
    wide_key   = (mode != simon128_pkg::MODE_128) && (mode != simon128_pkg::MODE_192);
    loading    = ({{(simon128_pkg::RND_W - simon128_pkg::KW_CNT_W){1'b0}}, num_w} > ctrl.rnd);
    src_calc   = num_w - 3'd1 - ctrl.rnd[simon128_pkg::KW_CNT_W-1:0];
    src_idx    = src_calc[1:0];
    old_idx    = 2'(num_w - 3'd1);
    last_dig   = (ctrl.dig == simon128_pkg::DIG_LAST);
    first_step = (ctrl.rnd == '0) && (ctrl.dig == '0);
  end

  // Key words are loaded first, newest word last
  always_comb begin
    src_word = key_word[src_idx];
    load_dig = src_word[D*int'(ctrl.dig) +: D];
  end

  // Derived key digit: c ^ seq ^ k[i-m] ^ t ^ (t ror 1), t = k[i-1] ror 3 (^ k[i-3])
  always_comb begin
    old_word = kq[old_idx];
    c_dig    = simon128_pkg::ROUND_C[D*int'(ctrl.dig) +: D];
    seq_mask = {{(D-1){1'b0}}, seq[0] & (ctrl.dig == '0)};
    t_lo     = kq[0][D+2:3] ^ ({D{wide_key}} & kq[2][D-1:0]);
    t_hi     = kq[0][D+3:4] ^ ({D{wide_key}} & kq[2][D:1]);
    calc_dig = c_dig ^ seq_mask ^ old_word[D-1:0] ^ t_lo ^ t_hi;
    key_dig  = loading ? load_dig : calc_dig;
  end

  // Advance the key window and the sequence bits
  always_ff @(posedge clk) begin
    if (ctrl.expand) begin
      nk <= {key_dig, nk[W-1:D]};
      if (last_dig) begin
        kq[0] <= {key_dig, nk[W-1:D]};
        for (int q = 1; q < simon128_pkg::NUM_KEY_WORDS; q++) begin
          kq[q] <= {kq[q-1][D-1:0], kq[q-1][W-1:D]};
        end
      end else begin
        for (int q = 0; q < simon128_pkg::NUM_KEY_WORDS; q++) begin
          kq[q] <= {kq[q][D-1:0], kq[q][W-1:D]};
        end
      end
      if (first_step) begin
        seq <= simon128_pkg::seq_init(mode);
      end else if (last_dig && !loading) begin
        seq <= seq >> 1;
      end
    end
  end

  // Round key store: write during expansion, registered read
  always_ff @(posedge clk) begin
    if (ctrl.expand) begin
      rk_mem[{ctrl.rnd, ctrl.dig}] <= key_dig;
    end
    rk_digit <= rk_mem[ctrl.rd_addr];
  end

endmodule
